// ===== rtl/bbc_pkg.sv =====
// Shared types and constants for the bracket balance checker.
package bbc_pkg;

  localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CHAR_OPEN_BRACE   = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE_BRACE  = 8'h7D;
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CHAR_NEWLINE      = 8'h0A;

  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_BRACE  = 2'd1;
  localparam logic [1:0] KIND_SQUARE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [2:0] VERDICT_BALANCED    = 3'd0;
  localparam logic [2:0] VERDICT_CLOSE_EMPTY = 3'd1;
  localparam logic [2:0] VERDICT_MISMATCH    = 3'd2;
  localparam logic [2:0] VERDICT_UNCLOSED    = 3'd3;
  localparam logic [2:0] VERDICT_OVERFLOW    = 3'd4;
  localparam logic [2:0] VERDICT_EMPTY       = 3'd5;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] kind;
  } stack_op_t;

endpackage

// ===== rtl/bbc_cell.sv =====
// One stack cell: holds a bracket kind and shifts with its neighbours.
module bbc_cell (
  input  logic               clk,
  input  bbc_pkg::stack_op_t op,
  input  logic [1:0]         from_above,
  input  logic [1:0]         from_below,
  output logic [1:0]         kind
);

  always_ff @(posedge clk) begin
    if (op.push) begin
      kind <= from_above;
    end else if (op.pop) begin
      kind <= from_below;
    end
  end

endmodule

// ===== rtl/bbc_stack.sv =====
// Shift-register bracket stack built from a chain of cells, top at cell zero.
module bbc_stack #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  bbc_pkg::stack_op_t op,
  output logic [1:0]         top_kind
);

  logic [1:0] cell_kind [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [1:0] above;
    logic [1:0] below;

    if (i == 0) begin : g_top
      assign above = op.kind;
    end else begin : g_mid
      assign above = cell_kind[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign below = bbc_pkg::KIND_NONE;
    end else begin : g_up
      assign below = cell_kind[i+1];
    end

    bbc_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .kind       (cell_kind[i])
    );
  end

  assign top_kind = cell_kind[0];

endmodule

// ===== rtl/bracket_balance_checker_unit.sv =====
// Top level of the bracket balance checker: control, level count and verdict register.
//
// Usage: bytes of an expression enter on the byte channel (char_code, last_char,
// byte_valid, byte_stall); one transfer per cycle is taken while byte_stall is low,
// at one byte per cycle sustained. Opening brackets push onto a chain of STACK_DEPTH
// cells, closing brackets pop it; every other byte is ignored. Each push or pop is
// one shift of the cell chain. On the byte with last_char set, one verdict transfer
// is registered and shown on the verdict channel (verdict, open_left, verdict_valid,
// verdict_stall) in the next cycle. Other bytes give no result.
// The first error of an expression is held and later brackets are ignored until
// the verdict; all expression state then clears for the next one.
// While verdict_valid and verdict_stall are both high the verdict is held and
// byte_stall is raised, so no byte is taken until the waiting verdict is transferred.
// Reset (rst, synchronous) clears the level, the held error, the first-byte flag
// and the output valid; the cell contents need no reset, as a cell is read only
// after it has been pushed.
module bracket_balance_checker_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       byte_valid,
  output logic       byte_stall,
  output logic [2:0] verdict,
  output logic [6:0] open_left,
  output logic       verdict_valid,
  input  logic       verdict_stall
);

  localparam int LW = $clog2(STACK_DEPTH + 1);

  logic [LW-1:0]      level;
  logic [LW-1:0]      level_next;
  logic [2:0]         held_error;
  logic [2:0]         held_error_next;
  logic               at_first;
  logic               fire;
  logic               is_empty;
  logic [1:0]         open_kind;
  logic [1:0]         close_kind;
  logic [1:0]         top_kind;
  logic [2:0]         verdict_next;
  logic [6:0]         left_sat;
  bbc_pkg::stack_op_t op;

  assign byte_stall = verdict_valid && verdict_stall;
  assign fire       = byte_valid && !byte_stall;
  assign is_empty   = last_char && at_first && (char_code == bbc_pkg::CHAR_NEWLINE);

  always_comb begin
    unique case (char_code)
      bbc_pkg::CHAR_OPEN_PAREN:  open_kind = bbc_pkg::KIND_PAREN;
      bbc_pkg::CHAR_OPEN_BRACE:  open_kind = bbc_pkg::KIND_BRACE;
      bbc_pkg::CHAR_OPEN_SQUARE: open_kind = bbc_pkg::KIND_SQUARE;
      default:                   open_kind = bbc_pkg::KIND_NONE;
    endcase
    unique case (char_code)
      bbc_pkg::CHAR_CLOSE_PAREN:  close_kind = bbc_pkg::KIND_PAREN;
      bbc_pkg::CHAR_CLOSE_BRACE:  close_kind = bbc_pkg::KIND_BRACE;
      bbc_pkg::CHAR_CLOSE_SQUARE: close_kind = bbc_pkg::KIND_SQUARE;
      default:                    close_kind = bbc_pkg::KIND_NONE;
    endcase
  end

  always_comb begin
    op              = '0;
    op.kind         = open_kind;
    level_next      = level;
    held_error_next = held_error;
    if (fire && !is_empty && held_error == bbc_pkg::VERDICT_BALANCED) begin
      if (open_kind != bbc_pkg::KIND_NONE) begin
        if (level == LW'(STACK_DEPTH)) begin
          held_error_next = bbc_pkg::VERDICT_OVERFLOW;
        end else begin
          op.push    = 1'b1;
          level_next = level + LW'(1);
        end
      end else if (close_kind != bbc_pkg::KIND_NONE) begin
        if (level == '0) begin
          held_error_next = bbc_pkg::VERDICT_CLOSE_EMPTY;
        end else begin
          op.pop     = 1'b1;
          level_next = level - LW'(1);
          if (top_kind != close_kind) begin
            held_error_next = bbc_pkg::VERDICT_MISMATCH;
          end
        end
      end
    end
  end

  always_comb begin
    priority if (is_empty) begin
      verdict_next = bbc_pkg::VERDICT_EMPTY;
    end else if (held_error_next != bbc_pkg::VERDICT_BALANCED) begin
      verdict_next = held_error_next;
    end else if (level_next != '0) begin
      verdict_next = bbc_pkg::VERDICT_UNCLOSED;
    end else begin
      verdict_next = bbc_pkg::VERDICT_BALANCED;
    end
  end

  if (LW <= 7) begin : g_left_narrow
    assign left_sat = 7'(level_next);
  end else begin : g_left_wide
    assign left_sat = (level_next > LW'(127)) ? 7'd127 : level_next[6:0];
  end

  bbc_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .op       (op),
    .top_kind (top_kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      held_error    <= bbc_pkg::VERDICT_BALANCED;
      at_first      <= 1'b1;
      verdict_valid <= 1'b0;
    end else begin
      if (fire && last_char) begin
        level      <= '0;
        held_error <= bbc_pkg::VERDICT_BALANCED;
        at_first   <= 1'b1;
      end else if (fire) begin
        level      <= level_next;
        held_error <= held_error_next;
        at_first   <= 1'b0;
      end
      verdict_valid <= (fire && last_char) || byte_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_char) begin
      verdict   <= verdict_next;
      open_left <= is_empty ? 7'd0 : left_sat;
    end
  end

endmodule

// ===== rtl/bbc_checker.sv =====
// Port-level assertions for the bracket balance checker, bound to the top level.
module bbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_stall,
  input logic [2:0] verdict,
  input logic [6:0] open_left,
  input logic       verdict_valid,
  input logic       verdict_stall
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !verdict_valid)
    else $error("verdict valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=>
      verdict_valid && $stable(verdict) && $stable(open_left))
    else $error("stalled verdict changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> verdict <= bbc_pkg::VERDICT_EMPTY)
    else $error("verdict code out of range");

  a_zero_left: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && (verdict == bbc_pkg::VERDICT_BALANCED ||
                      verdict == bbc_pkg::VERDICT_EMPTY ||
                      verdict == bbc_pkg::VERDICT_CLOSE_EMPTY) |-> open_left == 7'd0)
    else $error("opens left with a zero-level verdict");

  a_unclosed_left: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict == bbc_pkg::VERDICT_UNCLOSED |->
      open_left != 7'd0 && !(byte_stall && !verdict_stall))
    else $error("unclosed verdict with no opens left");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .byte_stall    (byte_stall),
  .verdict       (verdict),
  .open_left     (open_left),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall)
);
